>>> rtl/sswc_pkg.sv
// Types, round constants and round/schedule functions for the single-word SHA-256 block.
package sswc_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] state_t;
  typedef word_t [15:0] sched_t;

  // configuration register indexes
  localparam logic [7:0] REG_ROUND_COUNT    = 8'd0;
  localparam logic [7:0] REG_OUTPUT_WORD    = 8'd1;
  localparam logic [7:0] REG_INPUT_POSITION = 8'd2;
  localparam logic [7:0] REG_CARRYLESS      = 8'd3;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // modular add, or XOR in carry-free mode
  function automatic word_t add32(word_t a, word_t b, logic cl);
    return cl ? (a ^ b) : (a + b);
  endfunction

  function automatic word_t big_s0(word_t v);
    return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic word_t big_s1(word_t v);
    return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

  function automatic word_t small_s0(word_t v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
  endfunction

  function automatic word_t small_s1(word_t v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'd0, v[31:10]};
  endfunction

  // one compression round; index 0 is a, index 7 is h
  function automatic state_t round_f(state_t s, word_t k, word_t w, logic cl);
    word_t ch;
    word_t mj;
    word_t t1;
    word_t t2;
    state_t r;
    ch = (s[4] & s[5]) ^ (~s[4] & s[6]);
    mj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
    t1 = add32(add32(add32(add32(s[7], big_s1(s[4]), cl), ch, cl), k, cl), w, cl);
    t2 = add32(big_s0(s[0]), mj, cl);
    r[7] = s[6];
    r[6] = s[5];
    r[5] = s[4];
    r[4] = add32(s[3], t1, cl);
    r[3] = s[2];
    r[2] = s[1];
    r[1] = s[0];
    r[0] = add32(t1, t2, cl);
    return r;
  endfunction

  // window holds w[t..t+15]; slide by one and append w[t+16]
  function automatic sched_t sched_next(sched_t w, logic cl);
    sched_t r;
    for (int j = 0; j < 15; j++) begin
      r[j] = w[j+1];
    end
    r[15] = add32(add32(add32(small_s1(w[14]), w[9], cl), small_s0(w[1]), cl), w[0], cl);
    return r;
  endfunction

endpackage

>>> rtl/sha256_single_word_compress.sv
// Reduced-round SHA-256 compression of one word in a zero block, one round per stage.
//
//  channel | direction | ports                              | beat when
//  --------+-----------+------------------------------------+----------------------
//  in      | in        | in_valid, in_stall, in_message_word | in_valid & !in_stall
//  out     | out       | out_valid, out_stall, out_hash_word | out_valid & !out_stall
//  cfg     | in        | cfg_valid, cfg_ready, cfg_index,    | cfg_valid & cfg_ready
//          |           | cfg_data                           |
//
// One beat accepted per cycle while in_stall is low; a beat passes one stage per round,
// then the feed-forward add in the output register. Stages past round_count pass
// the state through. Each stage holds while its successor is full and stalled, so
// bubbles collapse and a stall drops nothing. Synchronous reset clears the valid
// bits and loads the register reset values.
module sha256_single_word_compress
  import sswc_pkg::*;
#(
  parameter int MAX_ROUNDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [6:0] round_count_r;
  logic [2:0] output_word_r;
  logic [3:0] input_position_r;
  logic       carryless_r;

  logic [6:0] rounds_eff;

  logic [MAX_ROUNDS-1:0] vld_r;
  state_t                st_r [MAX_ROUNDS];
  // the last stage needs no schedule window after it
  sched_t                w_r  [MAX_ROUNDS-1];
  logic [MAX_ROUNDS:0]   adv;

  sched_t w_in;

  logic  out_valid_r;
  word_t hash_word_r;
  word_t hash_word_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r    <= 7'd64;
      output_word_r    <= 3'd0;
      input_position_r <= 4'd0;
      carryless_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROUND_COUNT:    round_count_r    <= cfg_data[6:0];
        REG_OUTPUT_WORD:    output_word_r    <= cfg_data[2:0];
        REG_INPUT_POSITION: input_position_r <= cfg_data[3:0];
        REG_CARRYLESS:      carryless_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign rounds_eff = (round_count_r > 7'(MAX_ROUNDS)) ? 7'(MAX_ROUNDS) : round_count_r;

  // stage k may load when it is empty or its content moves on
  always_comb begin
    adv[MAX_ROUNDS] = !out_valid_r || !out_stall;
    for (int k = MAX_ROUNDS - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      w_in[j] = (input_position_r == 4'(j)) ? in_message_word : '0;
    end
  end

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_stage
    logic   src_vld;
    state_t src_st;
    sched_t src_w;
    logic   rnd_en;

    if (k == 0) begin : g_first
      always_comb begin
        src_vld = in_valid;
        for (int j = 0; j < 8; j++) begin
          src_st[j] = IV[j];
        end
        src_w = w_in;
      end
    end else begin : g_next
      assign src_vld = vld_r[k-1];
      assign src_st  = st_r[k-1];
      assign src_w   = w_r[k-1];
    end

    assign rnd_en = rounds_eff > 7'(k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && src_vld) begin
        st_r[k] <= rnd_en ? round_f(src_st, RC[k], src_w[0], carryless_r) : src_st;
      end
    end

    if (k < MAX_ROUNDS - 1) begin : g_sched
      always_ff @(posedge clk) begin
        if (adv[k] && src_vld) begin
          w_r[k] <= sched_next(src_w, carryless_r);
        end
      end
    end
  end

  assign hash_word_nxt = add32(st_r[MAX_ROUNDS-1][output_word_r], IV[output_word_r],
                               carryless_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv[MAX_ROUNDS]) begin
      out_valid_r <= vld_r[MAX_ROUNDS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[MAX_ROUNDS] && vld_r[MAX_ROUNDS-1]) begin
      hash_word_r <= hash_word_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hash_word = hash_word_r;

`ifndef NO_ASSERTIONS
  // a completely full, stalled pipe must push back on the input
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && (&vld_r)) |-> in_stall)
    else $error("input accepted while pipeline full and stalled");

  // the last stage's beat lands in the output register when it is free
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[MAX_ROUNDS-1] && adv[MAX_ROUNDS]) |=> out_valid)
    else $error("result lost between last round and output");

  // accepted beat occupies stage 0 next cycle
  a_in_to_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat missing from first stage");

  // round count write takes effect
  a_cfg_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_ROUND_COUNT) |=>
      (round_count_r == $past(cfg_data[6:0])))
    else $error("round count write not applied");
`endif

endmodule
